// ===== hw/rtl/mm4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_pkg: shared types and constants of the 4x4 matrix multiplier
// Holds the transaction payload structs, the controller command struct and
// the fixed field widths of the Q16.16 operands and results.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int DIM_DEF       = 4;
  localparam int FRAC_BITS_DEF = 16;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int PROD_W  = 2 * VALUE_W;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] a_value;
    logic signed [VALUE_W-1:0] b_value;
    logic        [POS_W-1:0]   position;
    logic                      last_load;
  } mm_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] product_value;
    logic        [POS_W-1:0]   out_position;
    logic                      last_result;
    logic                      saturated;
  } mm_out_t;

  // Command from the controller to the datapath, valid for one cycle.
  typedef struct packed {
    logic load;        // store the pair of the accepted transaction
    logic issue;       // one product term is issued this cycle
    logic first_term;  // first term of a result element
    logic last_term;   // last term of a result element
    logic last_elem;   // term belongs to the final result element
  } mm_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mm4_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_ctrl: sequencer of the matrix multiplier
// Accepts load transactions while idle, then walks column, row and term
// counters to issue one product term per cycle, and waits for the datapath
// to deliver the final result.
// ----------------------------------------------------------------------------
module mm4_ctrl #(
  parameter int DIM   = mm4_pkg::DIM_DEF,
  parameter int IDX_W = $clog2(DIM * DIM)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               last_load_i,
  input  wire logic               last_done_i,
  output logic                    busy,
  output mm4_pkg::mm_cmd_t        cmd_o,
  output logic [IDX_W-1:0]        a_addr_o,
  output logic [IDX_W-1:0]        b_addr_o,
  output logic [IDX_W-1:0]        elem_pos_o
);
  import mm4_pkg::*;

  localparam int CNT_W = $clog2(DIM);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIM - 1);
  localparam logic [IDX_W-1:0] DIM_IDX  = IDX_W'(DIM);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start & ~busy;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        col_d = '0;
        row_d = '0;
        k_d   = '0;
        if (accept && last_load_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_q == LAST_CNT) begin
          k_d = '0;
          if (row_q == LAST_CNT) begin
            row_d = '0;
            if (col_q == LAST_CNT) begin
              state_d = ST_DRAIN;
            end else begin
              col_d = col_q + CNT_W'(1);
            end
          end else begin
            row_d = row_q + CNT_W'(1);
          end
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (last_done_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      k_q     <= k_d;
    end
  end

  // Element A[row][k] sits at k*DIM+row, element B[k][col] at col*DIM+k.
  assign a_addr_o   = IDX_W'(k_q) * DIM_IDX + IDX_W'(row_q);
  assign b_addr_o   = IDX_W'(col_q) * DIM_IDX + IDX_W'(k_q);
  assign elem_pos_o = IDX_W'(col_q) * DIM_IDX + IDX_W'(row_q);

  always_comb begin
    cmd_o.load       = accept;
    cmd_o.issue      = (state_q == ST_RUN);
    cmd_o.first_term = (k_q == '0);
    cmd_o.last_term  = (k_q == LAST_CNT);
    cmd_o.last_elem  = (col_q == LAST_CNT) && (row_q == LAST_CNT);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mm4_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_datapath: operand stores and multiply-accumulate pipeline
// Two element stores with per-entry valid bits, a registered read stage,
// a 32x32 multiplier stage, an accumulator and a round-and-saturate stage
// that drives the result register.
// ----------------------------------------------------------------------------
module mm4_datapath #(
  parameter int DIM       = mm4_pkg::DIM_DEF,
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF,
  parameter int IDX_W     = $clog2(DIM * DIM)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mm4_pkg::mm_in_t  in_data_i,
  input  wire mm4_pkg::mm_cmd_t cmd_i,
  input  wire logic [IDX_W-1:0] a_addr_i,
  input  wire logic [IDX_W-1:0] b_addr_i,
  input  wire logic [IDX_W-1:0] elem_pos_i,
  output logic                  result_valid_o,
  output mm4_pkg::mm_out_t      result_o,
  output logic                  last_done_o
);
  import mm4_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int ACC_W = PROD_W + $clog2(DIM) + 1;
  localparam int SH_W  = ACC_W - FRAC_BITS;
  localparam logic [ACC_W-1:0] RND_HALF = {{(ACC_W - 1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  logic [VALUE_W-1:0] a_mem_q [CELLS];
  logic [VALUE_W-1:0] b_mem_q [CELLS];
  logic [CELLS-1:0]   vld_q;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;

  // Read stage
  logic [VALUE_W-1:0] a_rd_q, b_rd_q;
  logic               a_ok_q, b_ok_q;
  logic               s1_vld_q, s1_first_q, s1_last_q, s1_final_q;
  logic [IDX_W-1:0]   s1_pos_q;

  // Multiply stage
  logic signed [VALUE_W-1:0] a_op, b_op;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic                      s2_vld_q, s2_first_q, s2_last_q, s2_final_q;
  logic [IDX_W-1:0]          s2_pos_q;

  // Accumulate stage
  logic [ACC_W-1:0] prod_ext;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             acc_vld_q, acc_final_q;
  logic [IDX_W-1:0] acc_pos_q;

  // Round and saturate
  logic [ACC_W-1:0]    rnd;
  logic [SH_W-1:0]     shifted;
  logic [SH_W-32:0]    upper;
  logic                fits;
  mm_out_t             result_d, result_q;
  logic                strobe_q;

  // Positions outside the matrix are dropped on load.
  assign wr_en   = cmd_i.load && (int'(in_data_i.position) < CELLS);
  assign wr_addr = IDX_W'(in_data_i.position);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      a_mem_q[wr_addr] <= in_data_i.a_value;
      b_mem_q[wr_addr] <= in_data_i.b_value;
    end
    a_rd_q <= a_mem_q[a_addr_i];
    b_rd_q <= b_mem_q[b_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ok_q     <= 1'b0;
      b_ok_q     <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      acc_vld_q  <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      a_ok_q     <= vld_q[a_addr_i];
      b_ok_q     <= vld_q[b_addr_i];
      s1_vld_q   <= cmd_i.issue;
      s2_vld_q   <= s1_vld_q;
      acc_vld_q  <= s2_vld_q & s2_last_q;
      strobe_q   <= acc_vld_q;
    end
  end

  // Entries never written since reset read as zero.
  assign a_op   = a_ok_q ? a_rd_q : '0;
  assign b_op   = b_ok_q ? b_rd_q : '0;
  assign prod_d = a_op * b_op;

  always_ff @(posedge clk_i) begin
    s1_first_q  <= cmd_i.first_term;
    s1_last_q   <= cmd_i.last_term;
    s1_final_q  <= cmd_i.last_elem;
    s1_pos_q    <= elem_pos_i;
    prod_q      <= prod_d;
    s2_first_q  <= s1_first_q;
    s2_last_q   <= s1_last_q;
    s2_final_q  <= s1_final_q;
    s2_pos_q    <= s1_pos_q;
    acc_q       <= acc_d;
    acc_final_q <= s2_final_q;
    acc_pos_q   <= s2_pos_q;
    result_q    <= result_d;
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (s2_vld_q) begin
      acc_d = s2_first_q ? prod_ext : acc_q + prod_ext;
    end
  end

  // Adding half an LSB and dropping the fraction rounds halves upward.
  assign rnd     = acc_q + RND_HALF;
  assign shifted = rnd[ACC_W-1:FRAC_BITS];
  assign upper   = shifted[SH_W-1:31];
  assign fits    = (&upper) | ~(|upper);

  always_comb begin
    result_d = result_q;
    if (acc_vld_q) begin
      result_d.out_position = POS_W'(acc_pos_q);
      result_d.last_result  = acc_final_q;
      result_d.saturated    = ~fits;
      if (fits) begin
        result_d.product_value = shifted[VALUE_W-1:0];
      end else if (shifted[SH_W-1]) begin
        result_d.product_value = VALUE_MIN;
      end else begin
        result_d.product_value = VALUE_MAX;
      end
    end
  end

  assign result_valid_o = strobe_q;
  assign result_o       = result_q;
  assign last_done_o    = strobe_q & result_q.last_result;

endmodule
`default_nettype wire

// ===== hw/rtl/matrix_multiply_4x4_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_core: column-major Q16.16 matrix multiplier
// Loads two DIM x DIM matrices pairwise and computes R = A*B on request.
// ----------------------------------------------------------------------------
// Usage:
//   An input transaction is taken on a rising edge with start high and busy
//   low. It stores one element of A and of B at the given column-major
//   position. Loads are taken one per cycle; busy stays low between them.
//   A transaction with last_load set stores its pair and starts the multiply;
//   busy then stays high until the final result has been delivered.
//   Results leave in column-major order on result_o, each for one cycle with
//   result_valid_o high; the receiver cannot stall them. The last one has
//   last_result set, and saturated flags elements clipped to 32 bits.
//   Timing: one product term per cycle through the shared multiplier; each
//   term passes the read, multiply, accumulate and round stages, and busy
//   falls in the cycle after the final result has been delivered.
//   Reset clears both matrices to zero through per-entry valid bits; no
//   clearing pass is needed and loads are taken right after reset.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_core #(
  parameter int DIM       = mm4_pkg::DIM_DEF,
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire mm4_pkg::mm_in_t in_data_i,
  output logic                 result_valid_o,
  output mm4_pkg::mm_out_t     result_o
);
  import mm4_pkg::*;

  localparam int IDX_W = $clog2(DIM * DIM);

  mm_cmd_t          cmd;
  logic [IDX_W-1:0] a_addr;
  logic [IDX_W-1:0] b_addr;
  logic [IDX_W-1:0] elem_pos;
  logic             last_done;

  mm4_ctrl #(
    .DIM   (DIM),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_load_i (in_data_i.last_load),
    .last_done_i (last_done),
    .busy        (busy),
    .cmd_o       (cmd),
    .a_addr_o    (a_addr),
    .b_addr_o    (b_addr),
    .elem_pos_o  (elem_pos)
  );

  mm4_datapath #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS),
    .IDX_W     (IDX_W)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_data_i      (in_data_i),
    .cmd_i          (cmd),
    .a_addr_i       (a_addr),
    .b_addr_i       (b_addr),
    .elem_pos_i     (elem_pos),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .last_done_o    (last_done)
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for matrix_multiply_4x4_core
// Loads element pairs of A and B through the start/busy command port and
// computes the expected product matrix with its own Q16.16 model of the
// multiply, with rounding and saturation. Results from the result port are
// compared field by field in arrival order. The stimulus has directed cases
// for unwritten elements, saturation and rounding of halves, then random full
// and partial loads and mixed traffic under bursty start timing.
// ----------------------------------------------------------------------------
module testbench;
  import mm4_pkg::*;

  localparam int DIM             = DIM_DEF;
  localparam int FRAC_BITS       = FRAC_BITS_DEF;
  localparam int CELLS           = DIM * DIM;
  localparam int ACC_W           = 72;
  localparam int MULTIPLY_CYCLES = DIM * DIM * DIM + 8;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 72'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SUM_MAX    = 72'sd2147483647;
  localparam logic signed [ACC_W-1:0] SUM_MIN    = -72'sd2147483648;

  typedef enum int {MAG_FULL, MAG_MID, MAG_FRAC, MAG_EDGE} magnitude_e;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  mm_in_t  in_data_i;
  logic    result_valid_o;
  mm_out_t result_o;

  logic signed [VALUE_W-1:0] left_store  [CELLS];
  logic signed [VALUE_W-1:0] right_store [CELLS];
  mm_out_t                   pending_products [$];
  int unsigned               mismatch_count = 0;
  bit                        bursty = 1'b1;
  int                        burst_left = 4;

  matrix_multiply_4x4_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_data_i      (in_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stores the pair of an accepted transaction and, on the last load,
  // queues the sixteen product elements in column-major order.
  function automatic void store_and_multiply(input mm_in_t item);
    logic signed [ACC_W-1:0]     acc;
    logic signed [2*VALUE_W-1:0] term;
    logic signed [ACC_W-1:0]     rounded;
    mm_out_t                     element;
    int                          idx;
    if (item.position < CELLS) begin
      left_store[item.position]  = item.a_value;
      right_store[item.position] = item.b_value;
    end
    if (!item.last_load) return;
    for (int col = 0; col < DIM; col++) begin
      for (int row = 0; row < DIM; row++) begin
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
          term = left_store[k * DIM + row] * right_store[col * DIM + k];
          acc  = acc + term;
        end
        // Adding half an LSB before the arithmetic shift rounds halves up.
        rounded = (acc + ROUND_HALF) >>> FRAC_BITS;
        idx = col * DIM + row;
        element.out_position = POS_W'(idx);
        element.last_result  = (idx == CELLS - 1);
        if (rounded > SUM_MAX) begin
          element.product_value = VALUE_MAX;
          element.saturated     = 1'b1;
        end else if (rounded < SUM_MIN) begin
          element.product_value = VALUE_MIN;
          element.saturated     = 1'b1;
        end else begin
          element.product_value = rounded[VALUE_W-1:0];
          element.saturated     = 1'b0;
        end
        pending_products.push_back(element);
      end
    end
  endfunction

  function automatic void compare_field(input string field,
                                        input logic signed [31:0] expected_value,
                                        input logic signed [31:0] actual_value);
    if (expected_value !== actual_value) begin
      $error("%s: expected %0d, got %0d", field, expected_value, actual_value);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    mm_out_t oldest;
    if (rst_ni && result_valid_o) begin
      if (pending_products.size() == 0) begin
        $error("unexpected result at out_position %0d", result_o.out_position);
        mismatch_count++;
      end else begin
        oldest = pending_products.pop_front();
        compare_field("product_value", oldest.product_value, result_o.product_value);
        compare_field("out_position", oldest.out_position, result_o.out_position);
        compare_field("last_result", oldest.last_result, result_o.last_result);
        compare_field("saturated", oldest.saturated, result_o.saturated);
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] random_value(input magnitude_e mag);
    logic [31:0] raw;
    raw = $urandom;
    case (mag)
      MAG_FULL: return raw;
      MAG_MID:  return {{9{raw[22]}}, raw[22:0]};
      MAG_FRAC: return {{14{raw[17]}}, raw[17:0]};
      default: begin
        case ($urandom_range(0, 6))
          0:       return VALUE_MAX;
          1:       return VALUE_MIN;
          2:       return 32'h0001_0000;
          3:       return 32'hFFFF_0000;
          4:       return 32'h0000_0001;
          5:       return 32'hFFFF_FFFF;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic magnitude_e random_magnitude();
    case ($urandom_range(0, 9))
      0, 1:    return MAG_FULL;
      2, 3, 4: return MAG_FRAC;
      5:       return MAG_EDGE;
      default: return MAG_MID;
    endcase
  endfunction

  // Drops start for a random gap at the end of each burst.
  task automatic pace_sender();
    if (!bursty) return;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Start stays high after acceptance so that back-to-back transactions
  // need no second assignment in the same time step.
  task automatic send_item(input mm_in_t item);
    start     <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    store_and_multiply(item);
    pace_sender();
  endtask

  task automatic send_pair(input logic signed [VALUE_W-1:0] a,
                           input logic signed [VALUE_W-1:0] b,
                           input int pos, input bit last);
    mm_in_t item;
    item.a_value   = a;
    item.b_value   = b;
    item.position  = POS_W'(pos);
    item.last_load = last;
    send_item(item);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_unwritten_elements();
    send_pair(VALUE_MAX, VALUE_MAX, 0, 1'b0);
    send_pair(VALUE_MIN, VALUE_MIN, 15, 1'b1);
    drain_results();
  endtask

  task automatic test_saturation();
    send_pair(VALUE_MIN, VALUE_MAX, 5, 1'b1);
    send_pair(VALUE_MAX, VALUE_MIN, 10, 1'b0);
    send_pair(32'sh0100_0000, 32'sh0100_0000, 1, 1'b1);
    drain_results();
  endtask

  task automatic test_rounding_halves();
    send_pair(32'sh0000_0001, 32'sh0000_8000, 0, 1'b0);
    send_pair(-32'sh0000_0001, 32'sh0000_8000, 15, 1'b0);
    send_pair(32'sh0001_8000, -32'sh0000_8000, 5, 1'b0);
    send_pair(32'sh0000_0003, 32'sh0000_8000, 10, 1'b0);
    send_pair(32'sh0000_0000, 32'sh0000_0000, 1, 1'b0);
    send_pair(32'sh0000_0000, 32'sh0000_0000, 2, 1'b1);
    drain_results();
  endtask

  task automatic test_full_matrices(input int count);
    magnitude_e mag_a;
    magnitude_e mag_b;
    bit         descending;
    for (int s = 0; s < count; s++) begin
      mag_a      = random_magnitude();
      mag_b      = random_magnitude();
      descending = $urandom_range(0, 3) == 0;
      bursty     = $urandom_range(0, 3) != 0;
      for (int i = 0; i < CELLS; i++)
        send_pair(random_value(mag_a), random_value(mag_b),
                  descending ? CELLS - 1 - i : i, i == CELLS - 1);
      if (s == count / 2) drain_results();
    end
  endtask

  task automatic test_partial_updates(input int count);
    int n;
    for (int s = 0; s < count; s++) begin
      n      = $urandom_range(1, 6);
      bursty = $urandom_range(0, 2) != 0;
      for (int i = 0; i < n; i++)
        send_pair(random_value(random_magnitude()), random_value(random_magnitude()),
                  $urandom_range(0, CELLS - 1), i == n - 1);
    end
  endtask

  task automatic test_mixed_traffic(input int count);
    bursty = 1'b1;
    for (int i = 0; i < count; i++)
      send_pair(random_value(random_magnitude()), random_value(random_magnitude()),
                $urandom_range(0, CELLS - 1), ($urandom_range(0, 7) == 0) || (i == count - 1));
  endtask

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    in_data_i = '0;
    for (int i = 0; i < CELLS; i++) begin
      left_store[i]  = '0;
      right_store[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unwritten_elements();
    test_saturation();
    test_rounding_halves();
    test_full_matrices(9);
    test_partial_updates(12);
    test_mixed_traffic(40);

    drain_results();
    repeat (MULTIPLY_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_products.size() == 0) begin
      $display("matrix_multiply_4x4_core: match");
    end else begin
      $display("matrix_multiply_4x4_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("matrix_multiply_4x4_core: mismatch");
    $finish;
  end

endmodule
